// ----- sv/ust_pkg.sv -----
package ust_pkg;

  localparam int TABLE_DEPTH = 32;

  // Address width of the entry store and width of the fill counter.
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int VALUE_W  = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 5;
  localparam int FCNT_W   = 6;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIDX_W-1:0]   found_index;
    logic [FCNT_W-1:0]   fill_count;
  } out_t;

endpackage

// ----- sv/ust_ram.sv -----
module ust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/unsorted_set_table_core.sv -----
// Bounded unsorted table of signed 32-bit values with a fill count, held in
// one single-port-read RAM. Add, unused request types, and search or remove
// on an empty table go from accept straight to the result state; add writes
// at the fill position and allows duplicates. Otherwise search and remove scan
// the table one entry per cycle through the RAM's registered read port; a
// successful remove then reads the last entry and writes it into the freed
// slot. A new transaction is taken only while the sequencer is idle, but the
// finished result sits in an output register, so the next request may be
// accepted before the previous result is taken.
module unsorted_set_table_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ust_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ust_pkg::out_t  out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_FINISH
  } state_t;

  state_t                              state_r, state_nxt;
  logic [ust_pkg::REQ_W-1:0]           req_r, req_nxt;
  logic [ust_pkg::VALUE_W-1:0]         value_r, value_nxt;
  logic [ust_pkg::CNT_W-1:0]           count_r, count_nxt;
  logic [ust_pkg::IDX_W-1:0]           issue_r, issue_nxt;
  logic                                issuing_r, issuing_nxt;
  logic                                pend_r, pend_nxt;
  logic [ust_pkg::IDX_W-1:0]           cmp_idx_r, cmp_idx_nxt;
  logic [ust_pkg::IDX_W-1:0]           idx_r, idx_nxt;
  logic [ust_pkg::STATUS_W-1:0]        status_r, status_nxt;
  logic                                out_valid_r, out_valid_nxt;
  ust_pkg::out_t                       out_data_r, out_data_nxt;

  logic                                wr_en;
  logic [ust_pkg::IDX_W-1:0]           wr_addr;
  logic [ust_pkg::VALUE_W-1:0]         wr_data;
  logic                                rd_en;
  logic [ust_pkg::IDX_W-1:0]           rd_addr;
  logic [ust_pkg::VALUE_W-1:0]         rd_data;
  logic [ust_pkg::IDX_W-1:0]           last_idx;
  logic                                hit;

  ust_ram #(
    .WIDTH (ust_pkg::VALUE_W),
    .DEPTH (ust_pkg::TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Only meaningful while the table is not empty.
  assign last_idx = ust_pkg::IDX_W'(count_r - ust_pkg::CNT_W'(1));
  assign hit      = pend_r && (rd_data == value_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    issuing_nxt   = issuing_r;
    pend_nxt      = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    idx_nxt       = idx_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[ust_pkg::IDX_W-1:0];
    wr_data       = in_data.value;
    rd_en         = 1'b0;
    rd_addr       = issue_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data.req_type;
          value_nxt  = in_data.value;
          idx_nxt    = '0;
          status_nxt = ust_pkg::STATUS_OK;
          state_nxt  = ST_FINISH;
          case (in_data.req_type)
            ust_pkg::REQ_ADD: begin
              if (count_r >= ust_pkg::CNT_W'(ust_pkg::TABLE_DEPTH)) begin
                status_nxt = ust_pkg::STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + ust_pkg::CNT_W'(1);
              end
            end
            ust_pkg::REQ_REMOVE, ust_pkg::REQ_SEARCH: begin
              if (count_r == '0) begin
                status_nxt = ust_pkg::STATUS_NOT_FOUND;
              end else begin
                issue_nxt   = '0;
                issuing_nxt = 1'b1;
                state_nxt   = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Reads are issued one per cycle; the compare sees the word read
        // in the previous cycle.
        rd_en       = issuing_r;
        pend_nxt    = issuing_r;
        cmp_idx_nxt = issue_r;
        if (issuing_r) begin
          if (issue_r == last_idx) begin
            issuing_nxt = 1'b0;
          end else begin
            issue_nxt = issue_r + ust_pkg::IDX_W'(1);
          end
        end
        if (hit) begin
          idx_nxt  = cmp_idx_r;
          pend_nxt = 1'b0;
          if (req_r == ust_pkg::REQ_REMOVE) begin
            state_nxt = ST_MOVE_RD;
          end else begin
            state_nxt = ST_FINISH;
          end
        end else if (pend_r && !issuing_r) begin
          status_nxt = ust_pkg::STATUS_NOT_FOUND;
          pend_nxt   = 1'b0;
          state_nxt  = ST_FINISH;
        end
      end

      ST_MOVE_RD: begin
        rd_en     = 1'b1;
        rd_addr   = last_idx;
        state_nxt = ST_MOVE_WR;
      end

      ST_MOVE_WR: begin
        // The last entry fills the freed slot; the old last slot is beyond
        // the new count and is never read before it is written again.
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data;
        count_nxt = count_r - ust_pkg::CNT_W'(1);
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.found_index = ust_pkg::FIDX_W'(idx_r);
          out_data_nxt.fill_count  = ust_pkg::FCNT_W'(count_r);
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      issuing_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issuing_r   <= issuing_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    value_r    <= value_nxt;
    issue_r    <= issue_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- bench/unsorted_set_table_checker.sv -----
`timescale 1ns / 1ps

module unsorted_set_table_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  ust_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  ust_pkg::out_t out_data,
  output int            mismatch_count,
  output int            pending_count,
  output int            results_checked,
  output int            full_rejects,
  output int            lookup_misses
);

  localparam int REPORT_LIMIT = 10;

  logic signed [ust_pkg::VALUE_W-1:0] shadow_entries [ust_pkg::TABLE_DEPTH];
  int shadow_fill;
  ust_pkg::out_t predicted_results [$];

  int errors = 0;
  int checked = 0;
  int fulls = 0;
  int misses = 0;

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic ust_pkg::out_t apply_request(input ust_pkg::in_t req);
    ust_pkg::out_t res;
    int slot;
    int last;
    bit hit;
    res.status = ust_pkg::STATUS_OK;
    res.found_index = '0;
    slot = 0;
    hit = 1'b0;
    case (req.req_type)
      ust_pkg::REQ_ADD: begin
        if (shadow_fill >= ust_pkg::TABLE_DEPTH) begin
          res.status = ust_pkg::STATUS_FULL;
        end else begin
          shadow_entries[shadow_fill] = req.value;
          shadow_fill++;
        end
      end
      ust_pkg::REQ_REMOVE, ust_pkg::REQ_SEARCH: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (!hit && shadow_entries[i] == req.value) begin
            hit = 1'b1;
            slot = i;
          end
        end
        if (!hit) begin
          res.status = ust_pkg::STATUS_NOT_FOUND;
        end else begin
          res.found_index = ust_pkg::FIDX_W'(slot);
          if (req.req_type == ust_pkg::REQ_REMOVE) begin
            // The last valid entry fills the hole and its old slot is cleared.
            last = shadow_fill - 1;
            shadow_entries[slot] = shadow_entries[last];
            shadow_entries[last] = '0;
            shadow_fill = last;
          end
        end
      end
      default: begin
      end
    endcase
    res.fill_count = ust_pkg::FCNT_W'(shadow_fill);
    return res;
  endfunction

  always @(posedge clk) begin
    ust_pkg::out_t want;
    if (!rst_n) begin
      for (int i = 0; i < ust_pkg::TABLE_DEPTH; i++) begin
        shadow_entries[i] = '0;
      end
      shadow_fill = 0;
      predicted_results.delete();
    end else begin
      // Results are compared before new requests are queued, since a result
      // always belongs to an earlier transaction.
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("Unexpected result: status %0d index %0d count %0d",
                     out_data.status, out_data.found_index, out_data.fill_count);
          end
        end else begin
          want = predicted_results.pop_front();
          checked++;
          if (out_data.status !== want.status ||
              out_data.found_index !== want.found_index ||
              out_data.fill_count !== want.fill_count) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("Result %0d wrong: expected status %0d index %0d count %0d,",
                       checked, want.status, want.found_index, want.fill_count);
              $display("  got status %0d index %0d count %0d",
                       out_data.status, out_data.found_index, out_data.fill_count);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_request(in_data);
        if (want.status == ust_pkg::STATUS_FULL) fulls++;
        if (want.status == ust_pkg::STATUS_NOT_FOUND) misses++;
        predicted_results.push_back(want);
      end
    end
    mismatch_count <= errors;
    pending_count <= predicted_results.size();
    results_checked <= checked;
    full_rejects <= fulls;
    lookup_misses <= misses;
  end

endmodule

// ----- bench/tb_unsorted_set_table_core.sv -----
`timescale 1ns / 1ps

module tb_unsorted_set_table_core;

  localparam logic [ust_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 830;
  localparam int SEGMENT_ITEMS   = 60;
  localparam int PRESSURE_AFTER  = 300;
  localparam int PRESSURE_CYCLES = 500;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int TAIL_CYCLES     = 2 * ust_pkg::TABLE_DEPTH + 16;
  localparam int POOL_SIZE       = 16;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  ust_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  ust_pkg::out_t out_data;

  int mismatch_count;
  int pending_count;
  int results_checked;
  int full_rejects;
  int lookup_misses;

  int send_gap_max = 4;
  int recv_gap_max = 4;
  int idle_cycles = 0;
  int sent_by_kind [4];

  // Recently added values, so that lookups and removals mostly hit.
  logic signed [ust_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
  int pool_wr = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  unsorted_set_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  unsorted_set_table_checker table_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .full_rejects    (full_rejects),
    .lookup_misses   (lookup_misses)
  );

  function automatic int pick_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4;
      default: return 16;
    endcase
  endfunction

  function automatic logic signed [ust_pkg::VALUE_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic logic signed [ust_pkg::VALUE_W-1:0] pick_value(
    input logic [ust_pkg::REQ_W-1:0] kind
  );
    int roll;
    roll = $urandom_range(0, 9);
    if (kind == ust_pkg::REQ_ADD) begin
      if (roll < 5) return $urandom;
      if (roll < 7) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 8) return pick_extreme();
      return $signed({28'b0, 4'($urandom_range(0, 15))}) - 8;
    end
    if (roll < 7) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 8) return $urandom;
    return $signed({28'b0, 4'($urandom_range(0, 15))}) - 8;
  endfunction

  task automatic send_req(input logic [ust_pkg::REQ_W-1:0] kind,
                          input logic signed [ust_pkg::VALUE_W-1:0] v);
    ust_pkg::in_t req;
    int gap;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    req.req_type = kind;
    req.value = v;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_by_kind[kind]++;
    if (kind == ust_pkg::REQ_ADD) begin
      value_pool[pool_wr] = v;
      pool_wr = (pool_wr + 1) % POOL_SIZE;
    end
  endtask

  initial begin
    mix_t mix;
    logic [ust_pkg::REQ_W-1:0] kind;
    int roll;
    int add_pct;
    int remove_pct;
    for (int i = 0; i < POOL_SIZE; i++) begin
      value_pool[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      sent_by_kind[i] = 0;
    end
    mix = MIX_EVEN;
    add_pct = 0;
    remove_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Lookups on an empty table, then extremes, a duplicate, and removals of
    // the first entry, the last entry and one copy of a duplicate.
    send_req(ust_pkg::REQ_SEARCH, 32'h0000_0000);
    send_req(ust_pkg::REQ_REMOVE, 32'h0000_0005);
    send_req(ust_pkg::REQ_ADD, 32'h8000_0000);
    send_req(ust_pkg::REQ_ADD, 32'h7fff_ffff);
    send_req(ust_pkg::REQ_ADD, 32'hffff_ffff);
    send_req(ust_pkg::REQ_ADD, 32'h0000_0000);
    send_req(ust_pkg::REQ_ADD, 32'h7fff_ffff);
    send_req(ust_pkg::REQ_ADD, 32'h5555_5555);
    send_req(ust_pkg::REQ_ADD, 32'haaaa_aaaa);
    send_req(ust_pkg::REQ_SEARCH, 32'h7fff_ffff);
    send_req(ust_pkg::REQ_SEARCH, 32'h0000_0000);
    send_req(ust_pkg::REQ_SEARCH, 32'h1234_5678);
    send_req(REQ_UNUSED, 32'hffff_ffff);
    send_req(ust_pkg::REQ_REMOVE, 32'h8000_0000);
    send_req(ust_pkg::REQ_SEARCH, 32'haaaa_aaaa);
    send_req(ust_pkg::REQ_REMOVE, 32'h5555_5555);
    send_req(ust_pkg::REQ_REMOVE, 32'h7fff_ffff);
    send_req(ust_pkg::REQ_SEARCH, 32'h7fff_ffff);
    send_req(ust_pkg::REQ_REMOVE, 32'h1357_9bdf);
    send_req(REQ_UNUSED, 32'h0000_0000);

    // Each segment picks growing, shrinking or balanced traffic at random so the
    // table swings between empty and full.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        send_gap_max = pick_gap();
      end
      case (mix)
        MIX_GROW: begin
          add_pct = 70;
          remove_pct = 10;
        end
        MIX_SHRINK: begin
          add_pct = 20;
          remove_pct = 50;
        end
        default: begin
          add_pct = 38;
          remove_pct = 25;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 2) kind = REQ_UNUSED;
      else if (roll < 2 + add_pct) kind = ust_pkg::REQ_ADD;
      else if (roll < 2 + add_pct + remove_pct) kind = ust_pkg::REQ_REMOVE;
      else kind = ust_pkg::REQ_SEARCH;
      send_req(kind, pick_value(kind));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d add, %0d remove, %0d search, %0d unused type.",
             sent_by_kind[0] + sent_by_kind[1] + sent_by_kind[2] + sent_by_kind[3],
             sent_by_kind[ust_pkg::REQ_ADD], sent_by_kind[ust_pkg::REQ_REMOVE],
             sent_by_kind[ust_pkg::REQ_SEARCH], sent_by_kind[REQ_UNUSED]);
    $display("Checked %0d results; %0d adds refused on a full table, %0d lookups missed.",
             results_checked, full_rejects, lookup_misses);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: each result is held off for a random number of cycles once it
  // shows up, with one long hold-off that backs the block up into its input.
  initial begin
    int stall_len;
    int taken;
    bit pressed;
    taken = 0;
    pressed = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressed && taken == PRESSURE_AFTER) begin
        pressed = 1'b1;
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else begin
        stall_len = (recv_gap_max == 0) ? 0 : $urandom_range(0, recv_gap_max);
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          @(posedge clk);
          while (!out_valid) @(posedge clk);
          repeat (stall_len - 1) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 50 == 0) recv_gap_max = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
